// ----- sv/aprop_pkg.sv -----
package aprop_pkg;

    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int MODE_W  = 4;
    localparam int CIDX_W  = 3;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic [MODE_W-1:0] {
        ROP_COPY_RGB    = 4'd0,
        ROP_COPY_ALPHA  = 4'd1,
        ROP_RGB_UNDER   = 4'd2,
        ROP_RGB_ATLEAST = 4'd3,
        ROP_ALPHA_MAX   = 4'd4,
        ROP_ALPHA_MIN   = 4'd5,
        ROP_FILL_RGB    = 4'd6,
        ROP_BLEND       = 4'd7,
        ROP_FILL_ALPHA  = 4'd8
    } rop_mode_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_ALPHA_THRESHOLD = 3'd0,
        REG_FILL_RED        = 3'd1,
        REG_FILL_GREEN      = 3'd2,
        REG_FILL_BLUE       = 3'd3,
        REG_FILL_ALPHA      = 3'd4
    } reg_index_t;

    typedef struct packed {
        chan_t alpha_threshold;
        chan_t fill_red;
        chan_t fill_green;
        chan_t fill_blue;
        chan_t fill_alpha;
    } rop_cfg_t;

endpackage

// ----- sv/argb_pixel_raster_op_unit_core.sv -----
// ARGB8888 raster operation unit. Takes one destination/source pixel pair and a
// mode per transfer and returns the new destination pixel. Throughput is one
// pixel per clock while res_stall is low; a pixel passes the input register and
// the result register around the single combinational operation stage.
// Registers (threshold, fill color, fill alpha) are written through the cfg
// port, which is always ready; write them only while no pixel is in flight.
module argb_pixel_raster_op_unit_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aprop_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [aprop_pkg::CHAN_W-1:0]  cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [aprop_pkg::MODE_W-1:0]  mode,
    input  aprop_pkg::pixel_t             dst_pixel,
    input  aprop_pkg::pixel_t             src_pixel,
    output logic                          res_valid,
    input  logic                          res_stall,
    output aprop_pkg::pixel_t             new_pixel
);
    import aprop_pkg::*;

    rop_cfg_t                cfg_reg;
    rop_cfg_t                cfg_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [MODE_W-1:0]       mode_reg;
    pixel_t                  dst_reg;
    pixel_t                  src_reg;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    pixel_t                  res_reg;
    pixel_t                  res_next;
    logic                    s1_stall;
    logic                    in_load;
    logic                    res_load;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ALPHA_THRESHOLD: cfg_next.alpha_threshold = cfg_data;
                REG_FILL_RED:        cfg_next.fill_red        = cfg_data;
                REG_FILL_GREEN:      cfg_next.fill_green      = cfg_data;
                REG_FILL_BLUE:       cfg_next.fill_blue       = cfg_data;
                REG_FILL_ALPHA:      cfg_next.fill_alpha      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // result stage holds while the downstream stalls; input stage holds behind it
    assign s1_stall  = s2_valid_reg && res_stall;
    assign pix_stall = s1_valid_reg && s1_stall;
    assign in_load   = pix_valid && !pix_stall;
    assign res_load  = s1_valid_reg && !s1_stall;

    assign s1_valid_next = pix_stall ? s1_valid_reg : pix_valid;
    assign s2_valid_next = s1_stall  ? s2_valid_reg : s1_valid_reg;

    aprop_rop u_rop
    (
        .mode      (mode_reg),
        .dst_pixel (dst_reg),
        .src_pixel (src_reg),
        .cfg       (cfg_reg),
        .new_pixel (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            mode_reg <= mode;
            dst_reg  <= dst_pixel;
            src_reg  <= src_pixel;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = s2_valid_reg;
    assign new_pixel = res_reg;

endmodule

// ----- sv/aprop_rop.sv -----
module aprop_rop
(
    input  logic [aprop_pkg::MODE_W-1:0] mode,
    input  aprop_pkg::pixel_t            dst_pixel,
    input  aprop_pkg::pixel_t            src_pixel,
    input  aprop_pkg::rop_cfg_t          cfg,
    output aprop_pkg::pixel_t            new_pixel
);
    import aprop_pkg::*;

    // ((a+1)*f + (256-a)*d) >> 8; the sum never exceeds 255 * 257, so it fits in 16 bits
    function automatic chan_t blend_chan(input chan_t a, input chan_t f, input chan_t d);
        logic [CHAN_W:0]     w_fill;
        logic [CHAN_W:0]     w_dst;
        logic [2*CHAN_W:0]   sum;
        begin
            w_fill = {1'b0, a} + 9'd1;
            w_dst  = 9'd256 - {1'b0, a};
            sum    = ({{CHAN_W{1'b0}}, w_fill} * {{CHAN_W{1'b0}}, f})
                   + ({{CHAN_W{1'b0}}, w_dst} * {{CHAN_W{1'b0}}, d});
            blend_chan = sum[2*CHAN_W-1:CHAN_W];
        end
    endfunction

    chan_t  dst_a;
    chan_t  src_a;
    pixel_t src_rgb;
    pixel_t src_alpha;
    pixel_t blended;

    assign dst_a     = dst_pixel[31:24];
    assign src_a     = src_pixel[31:24];
    assign src_rgb   = {dst_a, src_pixel[23:0]};
    assign src_alpha = {src_a, dst_pixel[23:0]};
    assign blended   = {dst_a,
                        blend_chan(cfg.fill_alpha, cfg.fill_red,   dst_pixel[23:16]),
                        blend_chan(cfg.fill_alpha, cfg.fill_green, dst_pixel[15:8]),
                        blend_chan(cfg.fill_alpha, cfg.fill_blue,  dst_pixel[7:0])};

    always_comb
    begin
        unique case (rop_mode_t'(mode))
            ROP_COPY_RGB:    new_pixel = src_rgb;
            ROP_COPY_ALPHA:  new_pixel = src_alpha;
            ROP_RGB_UNDER:   new_pixel = (src_a <= cfg.alpha_threshold) ? src_rgb : dst_pixel;
            ROP_RGB_ATLEAST: new_pixel = (src_a >= cfg.alpha_threshold) ? src_rgb : dst_pixel;
            ROP_ALPHA_MAX:   new_pixel = (src_a > dst_a) ? src_alpha : dst_pixel;
            ROP_ALPHA_MIN:   new_pixel = (src_a < dst_a) ? src_alpha : dst_pixel;
            ROP_FILL_RGB:    new_pixel = {dst_a, cfg.fill_red, cfg.fill_green, cfg.fill_blue};
            ROP_BLEND:       new_pixel = blended;
            ROP_FILL_ALPHA:  new_pixel = {cfg.fill_alpha, dst_pixel[23:0]};
            default:         new_pixel = dst_pixel;
        endcase
    end

endmodule
